>>> rtl/fbfl_pkg.sv
// Shared types and constants for the fixed-size block free-list allocator.
`default_nettype none

package fbfl_pkg;

  // Pool geometry (fixed by the field widths)
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = 8;    // block index width
  localparam int unsigned PTR_W      = 9;    // index plus the "no link" code
  localparam int unsigned WORD_SHIFT = 3;    // log2 of the word size in bytes
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned BYTES_W    = 13;   // block_bytes register width
  localparam int unsigned COUNT_W    = 9;    // blocks_in_use / free count width
  localparam int unsigned WORDS_W    = 10;   // block size in words, up to 512
  localparam int unsigned OFFSET_W   = 20;

  localparam logic [PTR_W-1:0]   NO_LINK   = PTR_W'(MAX_BLOCKS);
  localparam logic [BYTES_W-1:0] BYTES_CAP = BYTES_W'(4096);
  localparam logic [BYTES_W-1:0] BYTES_MIN = BYTES_W'(WORD_BYTES);

  // Configuration register indexes
  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;   // capture the accepted input beat
    logic commit;  // update pool state and load the result register
  } cmd_t;

endpackage : fbfl_pkg

`default_nettype wire

>>> rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed-size block free-list allocator.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  action, block_index
//   result    out        out_valid/out_stall  status, granted_index,
//                                             granted_offset, free_count
//   config    in         wr_en                wr_index, wr_data
//
// Each beat is accepted in one step, which also reads the link store at
// the list head (registered read), and executed in the next, which updates
// the pool and loads the result register; the registered read sets this split.
// Reset rebuilds the pool with 256 blocks of 8 bytes; no clearing pass.
// A held result stalls the execute step only; the next beat is still
// accepted while the previous result waits on out_stall.
`default_nettype none

module fixed_block_free_list_allocator
  import fbfl_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  // config write port
  input  wire                 wr_en,
  input  wire                 wr_index,
  input  wire  [BYTES_W-1:0]  wr_data,
  // input beats
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [1:0]          action,
  input  wire  [IDX_W-1:0]    block_index,
  // result beats
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          status,
  output logic [IDX_W-1:0]    granted_index,
  output logic [OFFSET_W-1:0] granted_offset,
  output logic [COUNT_W-1:0]  free_count
);

  cmd_t cmd;

  // Sequence accept, execute and result hand-off
  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Hold pool state, link store and the result register
  fbfl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .action         (action),
    .block_index    (block_index),
    .status         (status),
    .granted_index  (granted_index),
    .granted_offset (granted_offset),
    .free_count     (free_count)
  );

endmodule : fixed_block_free_list_allocator

`default_nettype wire

>>> rtl/fbfl_ctrl.sv
// Sequencing controller: input accept, execute step, result register valid.
`default_nettype none

module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  output cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   accept;
  logic   slot_free;

  always_comb begin
    accept     = in_valid && (state == ST_IDLE);
    slot_free  = !out_valid || !out_stall;
    cmd.latch  = accept;
    cmd.commit = (state == ST_EXEC) && slot_free;
    in_stall   = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (cmd.commit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_to_exec : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted beat did not start execution");

  a_commit_gives_result : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result beat");

  a_commit_not_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !accept)
    else $error("commit and accept in the same cycle");

endmodule : fbfl_ctrl

`default_nettype wire

>>> rtl/fbfl_dp.sv
// Datapath: config registers, link store, list head, watermark, count, result.
`default_nettype none

module fbfl_dp
  import fbfl_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  cmd_t                cmd,
  input  wire                 wr_en,
  input  wire                 wr_index,
  input  wire  [BYTES_W-1:0]  wr_data,
  input  wire  [1:0]          action,
  input  wire  [IDX_W-1:0]    block_index,
  output logic [1:0]          status,
  output logic [IDX_W-1:0]    granted_index,
  output logic [OFFSET_W-1:0] granted_offset,
  output logic [COUNT_W-1:0]  free_count
);

  // Configuration registers
  logic [BYTES_W-1:0] block_bytes;
  logic [COUNT_W-1:0] blocks_in_use;

  // Pool state
  logic [PTR_W-1:0]   list_head;
  logic [PTR_W-1:0]   untouched_mark;
  logic [COUNT_W-1:0] free_total;
  logic [PTR_W-1:0]   pool_blocks;
  logic [WORDS_W-1:0] pool_words;

  // Captured input beat
  action_t          op_action;
  logic [IDX_W-1:0] op_index;

  // Link store, read at the list head every cycle
  logic [PTR_W-1:0] link_store [MAX_BLOCKS];
  logic [PTR_W-1:0] link_rd;

  // Next values
  logic [PTR_W-1:0]         list_head_next;
  logic [PTR_W-1:0]         untouched_mark_next;
  logic [COUNT_W-1:0]       free_total_next;
  logic [PTR_W-1:0]         pool_blocks_next;
  logic [WORDS_W-1:0]       pool_words_next;
  logic                     link_we;
  status_t                  status_next;
  logic [IDX_W-1:0]         granted_next;
  logic                     got;
  logic [BYTES_W-1:0]       req_bytes;
  logic [BYTES_W-1:0]       req_round;
  logic [IDX_W+WORDS_W-1:0] product;

  always_comb begin
    // Block size in words: clamp to the cap and the minimum, round up
    if (block_bytes > BYTES_CAP) begin
      req_bytes = BYTES_CAP;
    end else if (block_bytes < BYTES_MIN) begin
      req_bytes = BYTES_MIN;
    end else begin
      req_bytes = block_bytes;
    end
    req_round = req_bytes + BYTES_W'(WORD_BYTES - 1);

    list_head_next      = list_head;
    untouched_mark_next = untouched_mark;
    free_total_next     = free_total;
    pool_blocks_next    = pool_blocks;
    pool_words_next     = pool_words;
    link_we             = 1'b0;
    status_next         = STAT_OK;
    granted_next        = '0;
    got                 = 1'b0;

    case (op_action)
      ACT_INIT: begin
        pool_blocks_next    = (blocks_in_use > NO_LINK) ? NO_LINK : blocks_in_use;
        pool_words_next     = req_round[BYTES_W-1:WORD_SHIFT];
        list_head_next      = NO_LINK;
        untouched_mark_next = '0;
        free_total_next     = pool_blocks_next;
      end
      ACT_ALLOC: begin
        if (!list_head[PTR_W-1]) begin
          // Pop the linked part
          granted_next   = list_head[IDX_W-1:0];
          list_head_next = link_rd;
          got            = 1'b1;
        end else if (untouched_mark < pool_blocks) begin
          // Take from the untouched tail
          granted_next        = untouched_mark[IDX_W-1:0];
          untouched_mark_next = untouched_mark + PTR_W'(1);
          got                 = 1'b1;
        end else begin
          status_next = STAT_EMPTY;
        end
        if (got && (free_total != '0)) begin
          free_total_next = free_total - COUNT_W'(1);
        end
      end
      ACT_FREE: begin
        if ({1'b0, op_index} >= pool_blocks) begin
          status_next = STAT_RANGE;
        end else begin
          link_we        = 1'b1;
          list_head_next = {1'b0, op_index};
          if (free_total < NO_LINK) begin
            free_total_next = free_total + COUNT_W'(1);
          end
        end
      end
      default: ;
    endcase

    product = granted_next * pool_words;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= BYTES_W'(WORD_BYTES);
      blocks_in_use <= COUNT_W'(MAX_BLOCKS);
    end else if (wr_en) begin
      case (wr_index)
        REG_BLOCK_BYTES:   block_bytes   <= wr_data;
        REG_BLOCKS_IN_USE: blocks_in_use <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head      <= NO_LINK;
      untouched_mark <= '0;
      free_total     <= COUNT_W'(MAX_BLOCKS);
      pool_blocks    <= NO_LINK;
      pool_words     <= WORDS_W'(1);
    end else if (cmd.commit) begin
      list_head      <= list_head_next;
      untouched_mark <= untouched_mark_next;
      free_total     <= free_total_next;
      pool_blocks    <= pool_blocks_next;
      pool_words     <= pool_words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_action <= action_t'(action);
      op_index  <= block_index;
    end
    if (cmd.commit) begin
      status         <= status_next;
      granted_index  <= granted_next;
      granted_offset <= {product[OFFSET_W-WORD_SHIFT-1:0], {WORD_SHIFT{1'b0}}};
      free_count     <= free_total_next;
    end
  end

  // Link the freed block in front of the old head, once, at the commit edge
  always_ff @(posedge clk) begin
    if (cmd.commit && link_we) begin
      link_store[op_index] <= list_head;
    end
    link_rd <= link_store[list_head[IDX_W-1:0]];
  end

  a_total_bound : assert property (@(posedge clk) disable iff (rst)
    free_total <= NO_LINK)
    else $error("free count above pool capacity");

  a_mark_bound : assert property (@(posedge clk) disable iff (rst)
    untouched_mark <= pool_blocks)
    else $error("watermark passed the pool size");

  a_head_code : assert property (@(posedge clk) disable iff (rst)
    list_head[PTR_W-1] |-> (list_head == NO_LINK))
    else $error("list head holds an invalid code");

endmodule : fbfl_dp

`default_nettype wire

>>> test/fixed_block_free_list_allocator_test.sv
// Testbench for the fixed-size block free-list allocator: directed table plus random traffic.
module fixed_block_free_list_allocator_test;
  import fbfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass once the last result is in, before touching config or ending the run.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_BEATS   = 60;

  // Pool size written before each random phase; 300 clamps to the full pool.
  localparam logic [COUNT_W-1:0] PHASE_COUNT [PHASES] =
    '{9'd5, 9'd16, 9'd256, 9'd0, 9'd3, 9'd64, 9'd1, 9'd300};

  // One result beat as the block should produce it.
  typedef struct packed {
    status_t             st;
    logic [IDX_W-1:0]    gi;
    logic [OFFSET_W-1:0] go;
    logic [COUNT_W-1:0]  fc;
  } grant_t;

  // One row of the directed table: a register write or an input beat,
  // the latter with a hand-typed result where it is obvious.
  typedef struct packed {
    logic               is_write;
    logic               sel;
    logic [BYTES_W-1:0] wdata;
    action_t            act;
    logic [IDX_W-1:0]   idx;
    logic               typed;
    grant_t             want;
  } row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                wr_en = 1'b0;
  logic                wr_index = REG_BLOCK_BYTES;
  logic [BYTES_W-1:0]  wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  action_t             action = ACT_NOP;
  logic [IDX_W-1:0]    block_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [IDX_W-1:0]    granted_index;
  logic [OFFSET_W-1:0] granted_offset;
  logic [COUNT_W-1:0]  free_count;

  fixed_block_free_list_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .block_index    (block_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_index  (granted_index),
    .granted_offset (granted_offset),
    .free_count     (free_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Expected result beats, oldest first.
  grant_t      pending_grants [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  // Idle odds in percent per side; the receiver's odds and the hold-off
  // request are written with nonblocking assignments so it sees them a
  // clean cycle later.
  int unsigned send_idle_pct = 33;
  int unsigned take_idle_pct = 33;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // Shadow of the register file and the pool.
  logic [BYTES_W-1:0] cfg_bytes;
  logic [COUNT_W-1:0] cfg_count;
  logic [PTR_W-1:0]   pool_link [MAX_BLOCKS];
  logic [PTR_W-1:0]   pool_head;
  logic [PTR_W-1:0]   pool_mark;
  logic [COUNT_W-1:0] pool_free;
  logic [COUNT_W-1:0] pool_count;
  logic [BYTES_W-1:0] pool_stride;

  // Block pitch: clamp to 4096, raise to one word, round up to whole words.
  function automatic logic [BYTES_W-1:0] stride_for(logic [BYTES_W-1:0] req);
    int unsigned r;
    r = req;
    if (r > 4096) r = 4096;
    if (r < WORD_BYTES) r = WORD_BYTES;
    return BYTES_W'((r + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES);
  endfunction

  // Init: every block free, handed out in ascending order from the mark.
  function automatic void pool_rebuild();
    pool_count  = (cfg_count > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : cfg_count;
    pool_stride = stride_for(cfg_bytes);
    pool_head   = NO_LINK;
    pool_mark   = '0;
    pool_free   = pool_count;
  endfunction

  // Apply one beat to the shadow pool and return the result it yields.
  function automatic grant_t pool_outcome(action_t act, logic [IDX_W-1:0] idx);
    grant_t g;
    logic   got;
    g.st = STAT_OK;
    g.gi = '0;
    g.go = '0;
    got  = 1'b0;
    case (act)
      ACT_INIT: pool_rebuild();
      ACT_ALLOC: begin
        // Pop the linked part first, then fall back to the untouched tail.
        if (pool_head < NO_LINK) begin
          g.gi      = pool_head[IDX_W-1:0];
          pool_head = pool_link[pool_head[IDX_W-1:0]];
          got       = 1'b1;
        end else if (pool_mark < PTR_W'(pool_count)) begin
          g.gi      = pool_mark[IDX_W-1:0];
          pool_mark = pool_mark + PTR_W'(1);
          got       = 1'b1;
        end
        if (got) begin
          g.go = OFFSET_W'(int'(g.gi) * int'(pool_stride));
          if (pool_free != 0) pool_free = pool_free - COUNT_W'(1);
        end else begin
          g.st = STAT_EMPTY;
        end
      end
      ACT_FREE: begin
        // Double frees are pushed again; only the counter saturates.
        if (COUNT_W'(idx) >= pool_count) begin
          g.st = STAT_RANGE;
        end else begin
          pool_link[idx] = pool_head;
          pool_head      = PTR_W'(idx);
          if (pool_free < COUNT_W'(MAX_BLOCKS)) pool_free = pool_free + COUNT_W'(1);
        end
      end
      default: ;
    endcase
    g.fc = pool_free;
    return g;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // Compare one accepted result beat against the oldest expectation.
  task automatic check_grant();
    grant_t want;
    results_seen++;
    if (pending_grants.size() == 0) begin
      flag_mismatch($sformatf("result %0d with nothing outstanding: st=%0d idx=%0d",
                              results_seen, status, granted_index));
    end else begin
      want = pending_grants.pop_front();
      if (status !== want.st || granted_index !== want.gi ||
          granted_offset !== want.go || free_count !== want.fc)
        flag_mismatch($sformatf(
          "result %0d: got st=%0d idx=%0d off=%0d free=%0d, want st=%0d idx=%0d off=%0d free=%0d",
          results_seen, status, granted_index, granted_offset, free_count,
          want.st, want.gi, want.go, want.fc));
    end
  endtask

  // Receiver: check every beat taken, then pick next cycle's stall. A
  // toggle of hold_toggle starts a long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_grant();
      if (hold_toggle != hold_seen) begin
        hold_seen <= hold_toggle;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < take_idle_pct);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold the input side quiet until every result is in, then let the
  // block settle.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [BYTES_W-1:0] value);
    wait_until_idle();
    wr_en    <= 1'b1;
    wr_index <= sel;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    if (sel == REG_BLOCK_BYTES) cfg_bytes = value;
    else cfg_count = value[COUNT_W-1:0];
  endtask

  // Offer one beat after a random gap, hold it until taken, then predict.
  // Valid stays high on return, so a back-to-back beat needs no extra edge to raise it again.
  task automatic send_beat(action_t act, logic [IDX_W-1:0] idx, output grant_t outcome);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    block_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    outcome = pool_outcome(act, idx);
  endtask

  function automatic row_t beat_row(action_t a, logic [IDX_W-1:0] i);
    row_t r;
    r          = '0;
    r.act      = a;
    r.idx      = i;
    r.want.st  = STAT_OK;
    return r;
  endfunction

  function automatic row_t checked_row(action_t a, logic [IDX_W-1:0] i, status_t s,
                                       logic [IDX_W-1:0] gi, logic [OFFSET_W-1:0] go,
                                       logic [COUNT_W-1:0] fc);
    row_t r;
    r         = beat_row(a, i);
    r.typed   = 1'b1;
    r.want.st = s;
    r.want.gi = gi;
    r.want.go = go;
    r.want.fc = fc;
    return r;
  endfunction

  function automatic row_t reg_row(logic sel, logic [BYTES_W-1:0] value);
    row_t r;
    r          = beat_row(ACT_NOP, '0);
    r.is_write = 1'b1;
    r.sel      = sel;
    r.wdata    = value;
    return r;
  endfunction

  initial begin
    row_t               plan [$];
    grant_t             outcome;
    logic [IDX_W-1:0]   held_blocks [$];
    logic [IDX_W-1:0]   idx;
    logic [BYTES_W-1:0] bytes_val;
    logic [BYTES_W-1:0] count_wdata;
    action_t            act;
    int unsigned        r;
    int unsigned        k;

    // Reset acts as an init with 256 blocks of 8 bytes.
    cfg_bytes = BYTES_W'(8);
    cfg_count = COUNT_W'(MAX_BLOCKS);
    foreach (pool_link[i]) pool_link[i] = '0;
    pool_rebuild();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset pool: ascending allocs, top index, no-op, double free.
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK, 8'd0,   20'd0,    9'd255));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK, 8'd1,   20'd8,    9'd254));
    plan.push_back(checked_row(ACT_FREE,  8'd255, STAT_OK, 8'd0,   20'd0,    9'd255));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK, 8'd255, 20'd2040, 9'd254));
    plan.push_back(checked_row(ACT_NOP,   8'hA5,  STAT_OK, 8'd0,   20'd0,    9'd254));
    plan.push_back(checked_row(ACT_FREE,  8'd0,   STAT_OK, 8'd0,   20'd0,    9'd255));
    plan.push_back(checked_row(ACT_FREE,  8'd0,   STAT_OK, 8'd0,   20'd0,    9'd256));
    plan.push_back(beat_row(ACT_ALLOC, 8'hFF));
    plan.push_back(beat_row(ACT_ALLOC, 8'h5A));
    plan.push_back(checked_row(ACT_INIT,  8'd0,   STAT_OK, 8'd0,   20'd0,    9'd256));
    // Registers take effect only at the next init.
    plan.push_back(reg_row(REG_BLOCK_BYTES, 13'd8191));
    plan.push_back(reg_row(REG_BLOCKS_IN_USE, 13'd0));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK, 8'd0,   20'd0,    9'd255));
    // Zero-block pool: empty on alloc, every free out of range.
    plan.push_back(checked_row(ACT_INIT,  8'd0,   STAT_OK,    8'd0, 20'd0, 9'd0));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_EMPTY, 8'd0, 20'd0, 9'd0));
    plan.push_back(checked_row(ACT_FREE,  8'd0,   STAT_RANGE, 8'd0, 20'd0, 9'd0));
    // One-block pool of minimum size.
    plan.push_back(reg_row(REG_BLOCK_BYTES, 13'd1));
    plan.push_back(reg_row(REG_BLOCKS_IN_USE, 13'd1));
    plan.push_back(checked_row(ACT_INIT,  8'd0,   STAT_OK,    8'd0, 20'd0, 9'd1));
    plan.push_back(checked_row(ACT_FREE,  8'd0,   STAT_OK,    8'd0, 20'd0, 9'd2));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK,    8'd0, 20'd0, 9'd1));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK,    8'd0, 20'd0, 9'd0));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_EMPTY, 8'd0, 20'd0, 9'd0));
    plan.push_back(checked_row(ACT_FREE,  8'd1,   STAT_RANGE, 8'd0, 20'd0, 9'd0));
    // Largest blocks, clamped pool, counter saturating at the top.
    plan.push_back(reg_row(REG_BLOCK_BYTES, 13'd4096));
    plan.push_back(reg_row(REG_BLOCKS_IN_USE, 13'd511));
    plan.push_back(checked_row(ACT_INIT,  8'd0,   STAT_OK, 8'd0,   20'd0,       9'd256));
    plan.push_back(checked_row(ACT_FREE,  8'd255, STAT_OK, 8'd0,   20'd0,       9'd256));
    plan.push_back(checked_row(ACT_ALLOC, 8'd0,   STAT_OK, 8'd255, 20'd1044480, 9'd255));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].sel, plan[i].wdata);
      end else begin
        send_beat(plan[i].act, plan[i].idx, outcome);
        pending_grants.push_back(plan[i].typed ? plan[i].want : outcome);
      end
    end

    // Random phases: new geometry, init, then a mix of allocs and frees plus rare
    // inits and no-ops, with most frees returning blocks that were actually handed out.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: bytes_val = '0;
        1: bytes_val = 13'd8191;
        2: bytes_val = 13'd4096;
        3: bytes_val = 13'd7;
        default: bytes_val = BYTES_W'($urandom_range(0, 8191));
      endcase
      // Junk above bit 8 must be dropped by the pool-size register.
      count_wdata = BYTES_W'(PHASE_COUNT[ph]) |
                    BYTES_W'($urandom_range(0, 15) << COUNT_W);
      write_reg(REG_BLOCK_BYTES, bytes_val);
      write_reg(REG_BLOCKS_IN_USE, count_wdata);

      // Run one phase flat out on both sides.
      send_idle_pct = (ph == 2) ? 0 : 33;
      take_idle_pct <= (ph == 2) ? 0 : 33;
      // Hold the result side off while beats keep coming, so the block
      // fills and stalls its input.
      if (ph == 5) hold_toggle <= ~hold_toggle;

      held_blocks.delete();
      send_beat(ACT_INIT, IDX_W'($urandom_range(0, 255)), outcome);
      pending_grants.push_back(outcome);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, 255));
        if (r < 2) begin
          act = ACT_INIT;
        end else if (r < 6) begin
          act = ACT_NOP;
        end else if (r < 52) begin
          act = ACT_ALLOC;
        end else begin
          act = ACT_FREE;
          if (held_blocks.size() != 0 && r < 94) begin
            k   = $urandom_range(0, held_blocks.size() - 1);
            idx = held_blocks[k];
            held_blocks.delete(k);
          end
        end
        send_beat(act, idx, outcome);
        pending_grants.push_back(outcome);
        if (act == ACT_INIT) held_blocks.delete();
        else if (act == ACT_ALLOC && outcome.st == STAT_OK) held_blocks.push_back(outcome.gi);
      end

      // Pause the sender until every result of this phase is back.
      wait_until_idle();
    end

    // Drain, then give stray beats a chance to show up.
    wait_until_idle();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
